// ===== src/spectral_centroid_lin_log_assert.svh =====
// assertion macros used by the checker module scl_check
`ifndef SPECTRAL_CENTROID_LIN_LOG_ASSERT_SVH
`define SPECTRAL_CENTROID_LIN_LOG_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define SCL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spectral centroid check failed");

// next-cycle implication, also checked across reset
`define SCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("spectral centroid check failed");

`endif

// ===== src/scl_pkg.sv =====
package scl_pkg;

  localparam int IN_W    = 24;
  localparam int MAG_W   = 24;
  localparam int SQ_W    = 48;
  localparam int REM_W   = 26;
  localparam int LG_W    = 18;
  localparam int E_W     = 4;
  localparam int FRAC_W  = 24;
  localparam int Q30_W   = 31;
  localparam int SR_W    = 18;
  localparam int BS_W    = 13;
  localparam int OUT_W   = 25;
  localparam int STEP_W  = 5;

  localparam logic [OUT_W-1:0] SAT_OUT     = 25'd24576000;
  localparam logic [30:0]      LOG10_2_Q32 = 31'd1292913986;
  localparam logic [29:0]      LOG2_10_Q28 = 30'd891723283;
  localparam logic [SR_W-1:0]  SR_RESET    = 18'd48000;
  localparam logic [BS_W-1:0]  BS_RESET    = 13'd2048;

  // register indexes of the configuration port
  localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;
  localparam logic [0:0] REG_BLOCK_SIZE  = 1'b1;

  typedef enum logic [3:0] {
    F_IDLE, F_SQ_RE, F_SQ_IM, F_ROOT, F_LOGM, F_PROD, F_ACC, F_FIN
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV_LIN, B_DIV_LOG, B_MUL_LIN, B_MUL_EXP, B_DIV_HZ_LIN,
    B_POW, B_MUL_POW, B_DIV_HZ_LOG, B_OUT
  } back_state_t;

  // floor square root, used only on constants
  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = v;
    res   = '0;
    bit_v = 64'h1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(2^-j) in q30, by repeated floor square roots from 2.0
  function automatic logic [30:0] pow2_root(input int j);
    logic [63:0] r;
    r = 64'd2 << 30;
    for (int s = 0; s < j; s++) begin
      r = isqrt_const(r << 30);
    end
    return r[30:0];
  endfunction

endpackage

// ===== src/scl_fifo.sv =====
module scl_fifo #(
  parameter int W     = 134,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output logic [W-1:0] pop_data
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/scl_front.sv =====
module scl_front import scl_pkg::*; #(
  parameter int IDX_W = 11,
  localparam int PS_W  = MAG_W + IDX_W,
  localparam int LS_W  = PS_W + IDX_W,
  localparam int GS_W  = MAG_W + LG_W + IDX_W,
  localparam int REC_W = PS_W + LS_W + GS_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  bin_real,
  input  logic signed [IN_W-1:0]  bin_imag,
  input  logic [BS_W-1:0]         n_eff,
  output logic                    push,
  output logic [REC_W-1:0]        push_data,
  input  logic                    full
);

  localparam int LP_W = LG_W + MAG_W;

  front_state_t state;
  front_state_t state_next;

  logic [MAG_W-1:0]  re_abs;
  logic [MAG_W-1:0]  im_abs;
  logic [IDX_W-1:0]  idx;
  logic              last;
  logic [SQ_W-1:0]   sq;
  logic [SQ_W-1:0]   v;
  logic [REM_W-1:0]  rem;
  logic [MAG_W-1:0]  root;
  logic [STEP_W-1:0] step;
  logic [Q30_W-1:0]  m;
  logic [FRAC_W-1:0] frac;
  logic [E_W-1:0]    e;
  logic [LG_W-1:0]   lg;
  logic [PS_W-1:0]   linp;
  logic [LP_W-1:0]   logp;
  logic [PS_W-1:0]   ps;
  logic [LS_W-1:0]   ls;
  logic [GS_W-1:0]   gs;
  logic [IDX_W-1:0]  bin_counter;

  logic              accept;
  logic              frame_ok;
  logic              last_c;
  logic [E_W-1:0]    e_c;
  logic [Q30_W-1:0]  m_c;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [2*Q30_W-1:0] sqm;
  logic [31:0]       sq_top;
  logic [59:0]       lgp;

  assign in_stall  = (state != F_IDLE);
  assign accept    = in_valid && (state == F_IDLE);
  // a frame needs at least two bins
  assign frame_ok  = (n_eff[BS_W-1:1] >= (BS_W-1)'(2));
  assign last_c    = ((BS_W'(bin_counter) + BS_W'(1)) >= BS_W'(n_eff[BS_W-1:1]));
  assign push      = (state == F_FIN) && last && (ps != '0) && !full;
  assign push_data = {ps, ls, gs};

  // leading one of the bin index and the normalized mantissa
  always_comb begin
    e_c = '0;
    for (int b = 0; b < IDX_W; b++) begin
      if (idx[b]) begin
        e_c = E_W'(b);
      end
    end
    m_c = Q30_W'(idx) << (5'd30 - {1'b0, e_c});
  end

  // one square-root digit and one log squaring step
  assign rem_sh = {rem, v[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign sqm    = {{Q30_W{1'b0}}, m} * {{Q30_W{1'b0}}, m};
  assign sq_top = sqm[61:30];
  assign lgp    = 60'({e, frac}) * 60'(LOG10_2_Q32) + (60'd1 << 39);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept && frame_ok) begin
          state_next = F_SQ_RE;
        end
      end
      F_SQ_RE: state_next = F_SQ_IM;
      F_SQ_IM: state_next = F_ROOT;
      F_ROOT: begin
        if (step == STEP_W'(MAG_W-1)) begin
          state_next = F_LOGM;
        end
      end
      F_LOGM: state_next = F_PROD;
      F_PROD: state_next = F_ACC;
      F_ACC:  state_next = F_FIN;
      F_FIN: begin
        if (!(last && ps != '0 && full)) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // frame state: bin counter and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= '0;
      ps          <= '0;
      ls          <= '0;
      gs          <= '0;
    end else begin
      if (state == F_ACC && idx != '0) begin
        ps <= ps + PS_W'(root);
        ls <= ls + LS_W'(linp);
        gs <= gs + GS_W'(logp);
      end
      if (state == F_FIN) begin
        if (last) begin
          if (!(ps != '0 && full)) begin
            bin_counter <= '0;
            ps          <= '0;
            ls          <= '0;
            gs          <= '0;
          end
        end else begin
          bin_counter <= bin_counter + 1'b1;
        end
      end
    end
  end

  // per-bin datapath
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          re_abs <= bin_real[IN_W-1] ? MAG_W'(-bin_real) : MAG_W'(bin_real);
          im_abs <= bin_imag[IN_W-1] ? MAG_W'(-bin_imag) : MAG_W'(bin_imag);
          idx    <= bin_counter;
          last   <= last_c;
        end
      end
      F_SQ_RE: begin
        sq <= {{MAG_W{1'b0}}, re_abs} * {{MAG_W{1'b0}}, re_abs};
      end
      F_SQ_IM: begin
        v    <= sq + {{MAG_W{1'b0}}, im_abs} * {{MAG_W{1'b0}}, im_abs};
        rem  <= '0;
        root <= '0;
        step <= '0;
        m    <= m_c;
        e    <= e_c;
        frac <= '0;
      end
      F_ROOT: begin
        if (rem_sh >= trial) begin
          rem  <= REM_W'(rem_sh - trial);
          root <= {root[MAG_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[REM_W-1:0];
          root <= {root[MAG_W-2:0], 1'b0};
        end
        v <= v << 2;
        if (sq_top[31]) begin
          m    <= sq_top[31:1];
          frac <= {frac[FRAC_W-2:0], 1'b1};
        end else begin
          m    <= sq_top[30:0];
          frac <= {frac[FRAC_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
      end
      F_LOGM: begin
        lg   <= lgp[40 +: LG_W];
        linp <= PS_W'(idx) * PS_W'(root);
      end
      F_PROD: begin
        logp <= LP_W'(lg) * LP_W'(root);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/scl_div.sv =====
module scl_div #(
  parameter int DVD_W = 62,
  parameter int DVS_W = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] q;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic             qbit;
  logic [DVS_W-1:0] rem_next;

  // one restoring step per cycle
  assign rem_sh   = {rem, q[DVD_W-1]};
  assign qbit     = (rem_sh >= {1'b0, dvs});
  assign rem_next = qbit ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DVD_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      q   <= {q[DVD_W-2:0], qbit};
    end
  end

endmodule

// ===== src/scl_back.sv =====
module scl_back import scl_pkg::*; #(
  parameter int IDX_W = 11,
  localparam int PS_W  = MAG_W + IDX_W,
  localparam int LS_W  = PS_W + IDX_W,
  localparam int GS_W  = MAG_W + LG_W + IDX_W,
  localparam int REC_W = PS_W + LS_W + GS_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  input  logic [REC_W-1:0]   rec_data,
  output logic               rec_pop,
  input  logic [SR_W-1:0]    sample_rate,
  input  logic [BS_W-1:0]    n_eff,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   log_centroid,
  output logic [OUT_W-1:0]   lin_centroid
);

  localparam int MI_W  = IDX_W + 16;
  localparam int X_W   = LG_W + 8;
  localparam int Y_W   = X_W + 2;
  localparam int ML_W  = MI_W + SR_W;
  localparam int PW_W  = Q30_W + SR_W;
  localparam int D1    = (LS_W + 16 > GS_W + 8) ? LS_W + 16 : GS_W + 8;
  localparam int D2    = (ML_W - 8 > PW_W) ? ML_W - 8 : PW_W;
  localparam int DVD_W = (D1 > D2) ? D1 : D2;
  localparam int DVS_W = PS_W;

  back_state_t state;
  back_state_t state_next;

  logic [PS_W-1:0]   ps_r;
  logic [LS_W-1:0]   ls_r;
  logic [GS_W-1:0]   gs_r;
  logic [MI_W-1:0]   mi;
  logic [X_W-1:0]    x;
  logic [Y_W-1:0]    y;
  logic [ML_W-1:0]   linp;
  logic [Q30_W-1:0]  p;
  logic [PW_W-1:0]   pw;
  logic [STEP_W-1:0] pstep;
  logic [OUT_W-1:0]  lin_r;
  logic [OUT_W-1:0]  lg_r;
  logic              div_run;

  logic              div_state;
  logic              div_start;
  logic              div_done;
  logic [DVD_W-1:0]  dvd_c;
  logic [DVS_W-1:0]  dvs_c;
  logic [DVD_W-1:0]  quot;
  logic [OUT_W-1:0]  quot_sat;
  logic [E_W-1:0]    e_v;
  logic [FRAC_W-1:0] f_v;
  logic [4:0]        shamt;
  logic [X_W+29:0]   yp;
  logic [2*Q30_W-1:0] pp;
  logic              load_out;
  logic [Q30_W-1:0]  root_tab [FRAC_W];

  // roots 2^(2^-(24-k)) for fraction bit k
  for (genvar k = 0; k < FRAC_W; k++) begin : g_root
    localparam logic [Q30_W-1:0] RK = pow2_root(FRAC_W - k);
    assign root_tab[k] = RK;
  end

  assign e_v      = y[Y_W-1:FRAC_W];
  assign f_v      = y[FRAC_W-1:0];
  assign shamt    = 5'd22 - {1'b0, e_v};
  assign yp       = (X_W+30)'(x) * (X_W+30)'(LOG2_10_Q28);
  assign pp       = (2*Q30_W)'(p) * (2*Q30_W)'(root_tab[pstep]);
  assign rec_pop  = (state == B_IDLE) && rec_valid;
  assign load_out = (state == B_OUT) && (!out_valid || !out_stall);
  assign quot_sat = (quot > DVD_W'(SAT_OUT)) ? SAT_OUT : quot[OUT_W-1:0];

  assign div_state = (state == B_DIV_LIN) || (state == B_DIV_LOG) ||
                     (state == B_DIV_HZ_LIN) || (state == B_DIV_HZ_LOG);
  assign div_start = div_state && !div_run;

  // divider operand selection
  always_comb begin
    dvd_c = DVD_W'({ls_r, 16'd0});
    dvs_c = ps_r;
    case (state)
      B_DIV_LOG: begin
        dvd_c = DVD_W'({gs_r, 8'd0});
      end
      B_DIV_HZ_LIN: begin
        dvd_c = DVD_W'(linp[ML_W-1:8]);
        dvs_c = DVS_W'(n_eff);
      end
      B_DIV_HZ_LOG: begin
        dvd_c = DVD_W'(pw >> shamt);
        dvs_c = DVS_W'(n_eff);
      end
      default: begin
      end
    endcase
  end

  scl_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_c),
    .divisor  (dvs_c),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (rec_valid) begin
          state_next = B_DIV_LIN;
        end
      end
      B_DIV_LIN: begin
        if (div_done) begin
          state_next = B_DIV_LOG;
        end
      end
      B_DIV_LOG: begin
        if (div_done) begin
          state_next = B_MUL_LIN;
        end
      end
      B_MUL_LIN: state_next = B_MUL_EXP;
      B_MUL_EXP: state_next = B_DIV_HZ_LIN;
      B_DIV_HZ_LIN: begin
        if (div_done) begin
          state_next = B_POW;
        end
      end
      B_POW: begin
        if (pstep == '0) begin
          state_next = B_MUL_POW;
        end
      end
      B_MUL_POW: state_next = B_DIV_HZ_LOG;
      B_DIV_HZ_LOG: begin
        if (div_done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (load_out) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // divider handshake and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      div_run   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (div_start) begin
        div_run <= 1'b1;
      end else if (div_done) begin
        div_run <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-frame datapath
  always_ff @(posedge clk) begin
    if (rec_pop) begin
      ps_r <= rec_data[REC_W-1 -: PS_W];
      ls_r <= rec_data[GS_W +: LS_W];
      gs_r <= rec_data[GS_W-1:0];
    end
    if (load_out) begin
      log_centroid <= lg_r;
      lin_centroid <= lin_r;
    end
    case (state)
      B_DIV_LIN: begin
        if (div_done) begin
          mi <= quot[MI_W-1:0];
        end
      end
      B_DIV_LOG: begin
        if (div_done) begin
          x <= quot[X_W-1:0];
        end
      end
      B_MUL_LIN: begin
        linp <= ML_W'(mi) * ML_W'(sample_rate);
      end
      B_MUL_EXP: begin
        y     <= yp[28 +: Y_W];
        p     <= Q30_W'(1) << 30;
        pstep <= STEP_W'(FRAC_W-1);
      end
      B_DIV_HZ_LIN: begin
        if (div_done) begin
          lin_r <= quot_sat;
        end
      end
      B_POW: begin
        if (f_v[pstep]) begin
          p <= pp[30 +: Q30_W];
        end
        pstep <= pstep - 1'b1;
      end
      B_MUL_POW: begin
        pw <= PW_W'(p) * PW_W'(sample_rate);
      end
      B_DIV_HZ_LOG: begin
        if (div_done) begin
          lg_r <= quot_sat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/spectral_centroid_lin_log.sv =====
// Spectral centroid over a stream of complex bins, one bin per request in bin order;
// the block counts bins itself and a frame holds block_size/2 bins (bin 0 ignored).
// The accumulator takes no new bin until the last one is done: it squares the
// real and imaginary parts, runs a 24-step square root alongside the 24
// squarings of the log10 mantissa, then forms the products and sums. At the
// last bin of a frame the three sums go into a two-entry queue, and the back
// end turns them into the log and linear centroids (1/256 Hz, saturated at
// 24576000) with one shared bit-serial divider for four divisions plus a
// 24-step power-of-two loop, overlapping the next frame. A frame with a zero
// magnitude sum gives no result; a block_size below four gives none at all.
// block_size above MAX_BLOCK is clamped. Write configuration only while the
// block is idle.
module spectral_centroid_lin_log import scl_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] bin_real,
  input  logic signed [IN_W-1:0] bin_imag,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_W-1:0]       log_centroid,
  output logic [OUT_W-1:0]       lin_centroid,
  input  logic                   cfg_wr,
  input  logic [0:0]             cfg_index,
  input  logic [SR_W-1:0]        cfg_data
);

  localparam int NMAX  = (MAX_BLOCK < 8191) ? MAX_BLOCK : 8191;
  localparam int IDX_W = $clog2(NMAX / 2);
  localparam int PS_W  = MAG_W + IDX_W;
  localparam int LS_W  = PS_W + IDX_W;
  localparam int GS_W  = MAG_W + LG_W + IDX_W;
  localparam int REC_W = PS_W + LS_W + GS_W;

  logic [SR_W-1:0]  sample_rate;
  logic [BS_W-1:0]  block_size;
  logic [BS_W-1:0]  n_eff;
  logic             push;
  logic [REC_W-1:0] push_data;
  logic             full;
  logic             pop;
  logic             nonempty;
  logic [REC_W-1:0] pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SR_RESET;
      block_size  <= BS_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate <= cfg_data;
        REG_BLOCK_SIZE:  block_size  <= cfg_data[BS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective transform length
  assign n_eff = (block_size > BS_W'(NMAX)) ? BS_W'(NMAX) : block_size;

  scl_front #(
    .IDX_W(IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .bin_real  (bin_real),
    .bin_imag  (bin_imag),
    .n_eff     (n_eff),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  scl_fifo #(
    .W     (REC_W),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .pop_data  (pop_data)
  );

  scl_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (nonempty),
    .rec_data     (pop_data),
    .rec_pop      (pop),
    .sample_rate  (sample_rate),
    .n_eff        (n_eff),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .log_centroid (log_centroid),
    .lin_centroid (lin_centroid)
  );

endmodule

// ===== src/scl_check.sv =====
`include "spectral_centroid_lin_log_assert.svh"

module scl_check import scl_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [OUT_W-1:0]       log_centroid,
  input logic [OUT_W-1:0]       lin_centroid
);

  // no result right after reset
  `SCL_ASSERT_NEXT(a_reset_quiet, rst, !out_valid)

  // a stalled result stays offered
  `SCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall && !rst, out_valid)

  // a stalled result keeps its value
  `SCL_ASSERT_NEXT(a_out_stable, out_valid && out_stall && !rst,
    $stable(log_centroid) && $stable(lin_centroid))

  // results never exceed the saturation level
  `SCL_ASSERT_IMPL(a_out_range, out_valid,
    (log_centroid <= SAT_OUT) && (lin_centroid <= SAT_OUT))

endmodule

bind spectral_centroid_lin_log scl_check u_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .log_centroid (log_centroid),
  .lin_centroid (lin_centroid)
);

// ===== tb/scl_checker.sv =====
module scl_checker import scl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic signed [IN_W-1:0] bin_real,
  input  logic signed [IN_W-1:0] bin_imag,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [OUT_W-1:0]       log_centroid,
  input  logic [OUT_W-1:0]       lin_centroid,
  input  logic                   cfg_wr,
  input  logic [0:0]             cfg_index,
  input  logic [SR_W-1:0]        cfg_data,
  output int                     errors,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BINS_BLOCK = 4096;

  typedef struct packed {
    logic [OUT_W-1:0] log_hz;
    logic [OUT_W-1:0] lin_hz;
  } centroid_t;

  centroid_t       expected_centroids[$];
  bit [63:0]       rate_hz;
  bit [63:0]       xform_len;
  int unsigned     bin_idx;
  bit [63:0]       mag_total;
  bit [63:0]       idx_mag_total;
  bit [63:0]       logidx_mag_total;
  bit [63:0]       exp_roots[0:24];

  // floor square root
  function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
    bit [63:0] acc;
    bit [63:0] one;
    acc = 0;
    one = 64'h1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= acc + one) begin
        v   = v - (acc + one);
        acc = (acc >> 1) + one;
      end else begin
        acc = acc >> 1;
      end
      one = one >> 2;
    end
    return acc;
  endfunction

  // log10 of a bin index, q2.16
  function automatic bit [63:0] bin_log10(input int unsigned i);
    int        msb;
    bit [63:0] mant;
    bit [63:0] frac;
    bit [63:0] l2;
    msb  = 0;
    frac = 0;
    while (msb < 31 && (i >> (msb + 1)) != 0) msb++;
    mant = 64'(i) << (30 - msb);
    for (int k = 0; k < 24; k++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    l2 = (64'(msb) << 24) | frac;
    return (l2 * 64'd1292913986 + (64'd1 << 39)) >> 40;
  endfunction

  // 2^(f/2^24) in q30
  function automatic bit [63:0] frac_exp2(input bit [23:0] f);
    bit [63:0] p;
    p = 64'd1 << 30;
    for (int k = 23; k >= 0; k--) begin
      if (f[k]) p = (p * exp_roots[24 - k]) >> 30;
    end
    return p;
  endfunction

  function automatic bit [63:0] clip_hz(input bit [63:0] v);
    return (v > 64'(SAT_OUT)) ? 64'(SAT_OUT) : v;
  endfunction

  task automatic report_mismatch(input string what, input bit [63:0] want,
                                 input bit [63:0] got);
    $display("[%0t] mismatch %s: expected %0d got %0d", $time, what, want, got);
    errors++;
  endtask

  // accumulate one bin; at frame end queue the centroids
  task automatic accept_bin(input logic signed [IN_W-1:0] re,
                            input logic signed [IN_W-1:0] im);
    bit [63:0] n;
    bit [63:0] half;
    bit [63:0] ar;
    bit [63:0] ai;
    bit [63:0] mag;
    bit [63:0] mean_idx;
    bit [63:0] lin;
    bit [63:0] mean_log;
    bit [63:0] log2v;
    bit [63:0] ex;
    bit [63:0] lg;
    centroid_t c;
    n    = (xform_len > MAX_BINS_BLOCK) ? 64'(MAX_BINS_BLOCK) : xform_len;
    half = n / 2;
    if (half < 2) return;
    ar  = (re < 0) ? 64'(-64'sd1 * longint'(re)) : 64'(re);
    ai  = (im < 0) ? 64'(-64'sd1 * longint'(im)) : 64'(im);
    mag = floor_sqrt(ar * ar + ai * ai);
    if (bin_idx != 0) begin
      mag_total        += mag;
      idx_mag_total    += 64'(bin_idx) * mag;
      logidx_mag_total += bin_log10(bin_idx) * mag;
    end
    if (64'(bin_idx) + 1 >= half) begin
      if (mag_total != 0) begin
        mean_idx = (idx_mag_total << 16) / mag_total;
        lin      = (mean_idx * rate_hz) / (n * 256);
        mean_log = (logidx_mag_total << 8) / mag_total;
        log2v    = (mean_log * 64'd891723283) >> 28;
        ex       = log2v >> 24;
        if (ex >= 22) lg = 64'(SAT_OUT);
        else lg = (frac_exp2(log2v[23:0]) * rate_hz) / (n << (22 - ex));
        c.log_hz = clip_hz(lg);
        c.lin_hz = clip_hz(lin);
        expected_centroids.insert(expected_centroids.size(), c);
      end
      bin_idx          = 0;
      mag_total        = 0;
      idx_mag_total    = 0;
      logidx_mag_total = 0;
    end else begin
      bin_idx++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    exp_roots[0] = 64'd2 << 30;
    for (int j = 1; j <= 24; j++) exp_roots[j] = floor_sqrt(exp_roots[j-1] << 30);
  end

  // watch config, requests and results
  always @(posedge clk) begin
    if (rst) begin
      rate_hz          = 48000;
      xform_len        = 2048;
      bin_idx          = 0;
      mag_total        = 0;
      idx_mag_total    = 0;
      logidx_mag_total = 0;
      expected_centroids.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_centroids.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          centroid_t c;
          c = expected_centroids.pop_front();
          if (log_centroid !== c.log_hz) report_mismatch("log_centroid", c.log_hz, log_centroid);
          if (lin_centroid !== c.lin_hz) report_mismatch("lin_centroid", c.lin_hz, lin_centroid);
        end
      end
      // a request sees the settings from before a write at the same edge
      if (in_valid && !in_stall) accept_bin(bin_real, bin_imag);
      if (cfg_wr) begin
        if (cfg_index == REG_SAMPLE_RATE) rate_hz = 64'(cfg_data);
        else if (cfg_index == REG_BLOCK_SIZE) xform_len = 64'(cfg_data[BS_W-1:0]);
      end
    end
    pending = expected_centroids.size();
  end

endmodule

// ===== tb/tb_spectral_centroid_lin_log.sv =====
module tb_spectral_centroid_lin_log;
  import scl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 400;
  localparam int LONG_HOLD   = 4000;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [IN_W-1:0] bin_real;
  logic signed [IN_W-1:0] bin_imag;
  logic                   out_valid;
  logic                   out_stall;
  logic [OUT_W-1:0]       log_centroid;
  logic [OUT_W-1:0]       lin_centroid;
  logic                   cfg_wr;
  logic [0:0]             cfg_index;
  logic [SR_W-1:0]        cfg_data;
  int                     errors;
  int                     pending;
  int                     bins_sent;
  int                     cycles;
  bit                     quiet;
  bit                     hold_req;

  spectral_centroid_lin_log u_dut (.*);

  scl_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    out_stall = 0;
    forever begin
      if (hold_req) begin
        hold_req  = 0;
        out_stall <= 1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
    end
  end

  // one register write with no request offered alongside
  task automatic write_reg(input logic [0:0] idx, input logic [SR_W-1:0] val);
    in_valid  <= 0;
    cfg_wr    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr    <= 0;
    @(posedge clk);
  endtask

  // offer one bin request and wait for it to be taken
  task automatic send_bin(input logic signed [IN_W-1:0] re,
                          input logic signed [IN_W-1:0] im, input int gap_pct);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    bin_real <= re;
    bin_imag <= im;
    do @(posedge clk); while (in_stall);
    bins_sent++;
  endtask

  function automatic logic signed [IN_W-1:0] pick_part();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      2, 3:    return IN_W'($signed($urandom_range(0, 511)) - 256);
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count, input int gap_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_bin('0, '0, gap_pct);
      else send_bin(pick_part(), pick_part(), gap_pct);
    end
  endtask

  // drain every expected result, then let the block go idle
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic signed [IN_W-1:0] edge_vals[4];
    int                     sizes[12];
    int                     phase;
    rst       = 1;
    in_valid  = 0;
    bin_real  = '0;
    bin_imag  = '0;
    cfg_wr    = 0;
    cfg_index = REG_SAMPLE_RATE;
    cfg_data  = '0;
    bins_sent = 0;
    quiet     = 0;
    hold_req  = 0;
    edge_vals = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'shFFFFFF};
    sizes     = '{4, 5, 6, 7, 8, 9, 10, 16, 17, 32, 64, 256};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: two-bin frames over all corner pairs
    write_reg(REG_SAMPLE_RATE, 18'd1);
    write_reg(REG_BLOCK_SIZE, 18'd4);
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++) send_bin(edge_vals[a], edge_vals[b], 0);
    settle();

    // sizes below four consume bins without results
    write_reg(REG_BLOCK_SIZE, 18'd0);
    send_random(4, 20);
    write_reg(REG_BLOCK_SIZE, 18'd3);
    send_random(3, 20);
    settle();

    // oversize block clamps; then shrinking mid-frame closes the frame early
    write_reg(REG_SAMPLE_RATE, 18'd192000);
    write_reg(REG_BLOCK_SIZE, 18'h1FFF);
    send_random(40, 20);
    settle();
    write_reg(REG_BLOCK_SIZE, 18'd6);
    send_random(7, 0);
    settle();

    // random phases over assorted settings
    phase = 0;
    while (bins_sent < 1500) begin
      int sr;
      int bs;
      int gap;
      int count;
      case ($urandom_range(0, 4))
        0:       sr = 1;
        1:       sr = 192000;
        default: sr = $urandom_range(1, 192000);
      endcase
      bs    = sizes[$urandom_range(0, 11)];
      count = $urandom_range(30, 120);
      if (phase == 4) begin
        bs    = 1024;
        count = 520;
      end
      if ($urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(5, 40);
      write_reg(REG_SAMPLE_RATE, SR_W'(sr));
      write_reg(REG_BLOCK_SIZE, SR_W'(bs));
      if (phase == 1) begin
        write_reg(REG_BLOCK_SIZE, 18'd4);
        hold_req = 1;
      end
      send_random(count, gap);
      settle();
      phase++;
    end

    // final stretch with no idling
    quiet = 1;
    write_reg(REG_SAMPLE_RATE, 18'd44100);
    write_reg(REG_BLOCK_SIZE, 18'd8);
    send_random(150, 0);
    settle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
